@@ hw/rtl/fncr_pkg.sv @@
// Package for the four-neighbor count raster unit.
// Holds sizes, register indexes, the queue entry type and the cell value function.
// No dependencies.
package fncr_pkg;

  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int VALUE_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [VALUE_W-1:0] OCCUPIED_VALUE = 4'd9;

  // one queue entry: an optional lagging result and an optional final-row flush
  typedef struct packed {
    logic                  has_lag;
    logic [VALUE_W-1:0]    lag_value;
    logic                  lag_eor;
    logic                  flush;
    logic [MAX_COLS-1:0]   flush_cur;
    logic [MAX_COLS-1:0]   flush_up;
    logic [COLS_CFG_W-1:0] cols;
  } job_t;

  function automatic logic [VALUE_W-1:0] cell_result(input logic centre, input logic up,
                                                     input logic down, input logic left,
                                                     input logic right);
    logic [VALUE_W-1:0] sum;
    sum = VALUE_W'(up) + VALUE_W'(down) + VALUE_W'(left) + VALUE_W'(right);
    return centre ? OCCUPIED_VALUE : sum;
  endfunction

endpackage

@@ hw/rtl/fncr_in_if.sv @@
// Input channel of the four-neighbor count raster unit: one grid cell per transaction.
// Depends on nothing.
interface fncr_in_if;
  logic valid;
  logic ready;
  logic occupied;

  modport source (output valid, output occupied, input ready);
  modport sink (input valid, input occupied, output ready);
endinterface

@@ hw/rtl/fncr_out_if.sv @@
// Output channel of the four-neighbor count raster unit: one cell result per transaction.
// Depends on fncr_pkg.
interface fncr_out_if;
  import fncr_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] cell_value;
  logic               end_of_row;
  logic               end_of_frame;

  modport source (output valid, output cell_value, output end_of_row, output end_of_frame,
                  input ready);
  modport sink (input valid, input cell_value, input end_of_row, input end_of_frame,
                output ready);
endinterface

@@ hw/rtl/four_neighbor_count_raster_unit.sv @@
// Four-neighbor count over a binary grid streamed in raster order.
// Depends on fncr_pkg, fncr_in_if, fncr_out_if, fncr_front, fncr_queue, fncr_back.
//
// Usage:
//   cells carries one grid cell per transaction (occupied), row by row, left to right.
//   results carries one value per cell: 9 when the cell is occupied, else the number
//   of occupied up/down/left/right neighbors inside the grid, with end_of_row and
//   end_of_frame flags.
//   grid_rows (index 0) and grid_cols (index 1) are written through wr_en, wr_index
//   and wr_data while the unit is idle; any write restarts the frame at row 0, col 0.
//   Results lag one row: a cell's value is sent when the cell below it arrives.
//   The last cell of the frame also releases the whole final row.
// Timing:
//   a lagging result passes the queue and the output register; the final row follows
//   at one cell a cycle unless stalled. One cell per cycle is accepted while the queue
//   has room; a multi-row frame's first row sends no jobs, hiding the final row walk.
// Reset: synchronous rst clears registers to one row, one column, position 0,
//   empty line stores and an empty queue.
// Stall: while results.ready is low the output register holds, the queue fills and
//   cells.ready drops.
module four_neighbor_count_raster_unit
  import fncr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  fncr_in_if.sink               cells,
  fncr_out_if.source            results
);

  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  fncr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .cells      (cells),
    .queue_full (full),
    .job_push   (push),
    .job        (push_job)
  );

  fncr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  fncr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .queue_job   (pop_job),
    .queue_pop   (pop),
    .results     (results)
  );

endmodule

@@ hw/rtl/fncr_front.sv @@
// Front end: configuration registers, raster position, three line stores.
// Turns each input cell into a queue entry. Depends on fncr_pkg and fncr_in_if.
module fncr_front
  import fncr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  fncr_in_if.sink               cells,
  input  logic                  queue_full,
  output logic                  job_push,
  output job_t                  job
);

  logic [ROWS_CFG_W-1:0] grid_rows;
  logic [COLS_CFG_W-1:0] grid_cols;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [MAX_COLS-1:0]   row_arriving;
  logic [MAX_COLS-1:0]   row_one_back;
  logic [MAX_COLS-1:0]   row_two_back;

  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [COLS_CFG_W-1:0] cols_eff;
  logic                  accept;
  logic                  last_col;
  logic                  last_row;
  logic [MAX_COLS-1:0]   arriving_next;
  logic [MAX_COLS-1:0]   left_vec;
  logic [MAX_COLS-1:0]   right_vec;
  logic                  up_bit;
  logic                  left_bit;
  logic                  right_bit;

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = ROWS_CFG_W'(1);
    end else if (grid_rows > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_eff = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_eff = COLS_CFG_W'(1);
    end else if (grid_cols > COLS_CFG_W'(MAX_COLS)) begin
      cols_eff = COLS_CFG_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols;
    end
  end

  assign cells.ready = !queue_full;
  assign accept      = cells.valid && !queue_full;
  assign last_col    = ({1'b0, col} == cols_eff - COLS_CFG_W'(1));
  assign last_row    = ({1'b0, row} == rows_eff - ROWS_CFG_W'(1));

  always_comb begin
    arriving_next      = row_arriving;
    arriving_next[col] = cells.occupied;
  end

  // neighbor bits of the row above, shifted so column zero and overflow read as empty
  assign left_vec  = {row_one_back[MAX_COLS-2:0], 1'b0};
  assign right_vec = {1'b0, row_one_back[MAX_COLS-1:1]};
  assign up_bit    = (row > ROW_W'(1)) ? row_two_back[col] : 1'b0;
  assign left_bit  = left_vec[col];
  assign right_bit = last_col ? 1'b0 : right_vec[col];

  always_comb begin
    job.has_lag   = (row != '0);
    job.lag_value = cell_result(row_one_back[col], up_bit, cells.occupied, left_bit, right_bit);
    job.lag_eor   = last_col;
    job.flush     = last_col && last_row;
    job.flush_cur = arriving_next;
    job.flush_up  = (row != '0) ? row_one_back : '0;
    job.cols      = cols_eff;
    job_push      = accept && (job.has_lag || job.flush);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= ROWS_CFG_W'(1);
      grid_cols    <= COLS_CFG_W'(1);
      col          <= '0;
      row          <= '0;
      row_arriving <= '0;
      row_one_back <= '0;
      row_two_back <= '0;
    end else begin
      if (accept) begin
        row_arriving <= arriving_next;
        if (last_col) begin
          col <= '0;
          if (last_row) begin
            row <= '0;
          end else begin
            row_two_back <= row_one_back;
            row_one_back <= arriving_next;
            row          <= row + ROW_W'(1);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
      // a register write restarts the frame
      if (wr_en) begin
        unique case (wr_index)
          REG_GRID_ROWS: grid_rows <= wr_data[ROWS_CFG_W-1:0];
          REG_GRID_COLS: grid_cols <= wr_data[COLS_CFG_W-1:0];
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/fncr_queue.sv @@
// Two-entry queue of jobs between the front end and the back end.
// Depends on fncr_pkg.
module fncr_queue
  import fncr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int DEPTH = 2;

  job_t       entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/fncr_back.sv @@
// Back end: takes jobs from the queue and emits results through an output register.
// Walks the final row one cell a cycle unless stalled. Depends on fncr_pkg, fncr_out_if.
module fncr_back
  import fncr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  input  job_t       queue_job,
  output logic       queue_pop,
  fncr_out_if.source results
);

  logic                  lag_pend;
  logic                  flush_pend;
  logic [VALUE_W-1:0]    lag_value;
  logic                  lag_eor;
  logic [MAX_COLS-1:0]   cur_sh;
  logic [MAX_COLS-1:0]   up_sh;
  logic                  left_prev;
  logic [COLS_CFG_W-1:0] pos;
  logic [COLS_CFG_W-1:0] cols;

  logic                  out_valid;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_eor;
  logic                  out_eof;

  logic                  busy;
  logic                  slot_free;
  logic                  step;
  logic                  last;
  logic                  finish;
  logic                  load;
  logic                  right_bit;
  logic [VALUE_W-1:0]    res_value;
  logic                  res_eor;
  logic                  res_eof;

  assign busy      = lag_pend || flush_pend;
  assign slot_free = !out_valid || results.ready;
  assign step      = busy && slot_free;
  assign last      = (pos + COLS_CFG_W'(1) == cols);
  assign right_bit = last ? 1'b0 : cur_sh[1];

  always_comb begin
    if (lag_pend) begin
      res_value = lag_value;
      res_eor   = lag_eor;
      res_eof   = 1'b0;
      finish    = step && !flush_pend;
    end else begin
      res_value = cell_result(cur_sh[0], up_sh[0], 1'b0, left_prev, right_bit);
      res_eor   = last;
      res_eof   = last;
      finish    = step && last;
    end
  end

  assign load      = (!busy || finish) && !queue_empty;
  assign queue_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_pend   <= 1'b0;
      flush_pend <= 1'b0;
    end else if (load) begin
      lag_pend   <= queue_job.has_lag;
      flush_pend <= queue_job.flush;
    end else if (step) begin
      if (lag_pend) begin
        lag_pend <= 1'b0;
      end else if (last) begin
        flush_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lag_value <= queue_job.lag_value;
      lag_eor   <= queue_job.lag_eor;
      cur_sh    <= queue_job.flush_cur;
      up_sh     <= queue_job.flush_up;
      cols      <= queue_job.cols;
      left_prev <= 1'b0;
      pos       <= '0;
    end else if (step && !lag_pend) begin
      // final row walks right one cell per step
      cur_sh    <= {1'b0, cur_sh[MAX_COLS-1:1]};
      up_sh     <= {1'b0, up_sh[MAX_COLS-1:1]};
      left_prev <= cur_sh[0];
      pos       <= pos + COLS_CFG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_value <= res_value;
      out_eor   <= res_eor;
      out_eof   <= res_eof;
    end
  end

  assign results.valid        = out_valid;
  assign results.cell_value   = out_value;
  assign results.end_of_row   = out_eor;
  assign results.end_of_frame = out_eof;

endmodule

@@ bench/fncr_checker.sv @@
// Checker for the four-neighbor count raster unit: mirrors the line stores and grid
// position, predicts each cell result and compares it with the results channel.
// Depends on fncr_pkg, fncr_in_if and fncr_out_if.
module fncr_checker
  import fncr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  fncr_in_if                    cells,
  fncr_out_if                   results,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               eor;
    logic               eof;
  } cell_out_t;

  cell_out_t             expected_cells[$];
  logic [MAX_COLS-1:0]   line_two_back;
  logic [MAX_COLS-1:0]   line_one_back;
  logic [MAX_COLS-1:0]   line_now;
  int unsigned           col_at;
  int unsigned           row_at;
  logic [ROWS_CFG_W-1:0] rows_reg;
  logic [COLS_CFG_W-1:0] cols_reg;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [VALUE_W-1:0] four_count(input logic centre, input logic up,
                                                    input logic down, input logic left,
                                                    input logic right);
    if (centre) return OCCUPIED_VALUE;
    return VALUE_W'($countones({up, down, left, right}));
  endfunction

  // zero acts as one, oversized values saturate
  function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void advance_grid(input logic occ);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned c;
    int unsigned r;
    logic        up;
    logic        left;
    logic        right;
    logic        last;
    nrows = fit_size(rows_reg, MAX_ROWS);
    ncols = fit_size(cols_reg, MAX_COLS);
    c = (col_at >= ncols) ? ncols - 1 : col_at;
    r = (row_at >= nrows) ? nrows - 1 : row_at;
    line_now[c] = occ;
    // the row above is complete once the cell below it arrives
    if (r > 0) begin
      up    = (r > 1) ? line_two_back[c] : 1'b0;
      left  = (c > 0) ? line_one_back[c - 1] : 1'b0;
      right = (c + 1 < ncols) ? line_one_back[c + 1] : 1'b0;
      expected_cells.push_back(cell_out_t'{
        four_count(line_one_back[c], up, line_now[c], left, right), c + 1 == ncols, 1'b0});
    end
    if (c + 1 == ncols) begin
      if (r + 1 == nrows) begin
        // last cell of the frame flushes the final row, nothing below it
        for (int j = 0; j < ncols; j++) begin
          up    = (r > 0) ? line_one_back[j] : 1'b0;
          left  = (j > 0) ? line_now[j - 1] : 1'b0;
          right = (j + 1 < ncols) ? line_now[j + 1] : 1'b0;
          last  = (j + 1 == ncols);
          expected_cells.push_back(cell_out_t'{
            four_count(line_now[j], up, 1'b0, left, right), last, last});
        end
        row_at = 0;
      end else begin
        line_two_back = line_one_back;
        line_one_back = line_now;
        row_at = r + 1;
      end
      col_at = 0;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
  endfunction

  function automatic void report(input string what, input bit has_want,
                                 input cell_out_t want, input cell_out_t got);
    errors++;
    if (errors <= 10) begin
      if (has_want)
        $display("%0t: %s: expected value %0d eor %0b eof %0b, got value %0d eor %0b eof %0b",
                 $time, what, want.value, want.eor, want.eof, got.value, got.eor, got.eof);
      else
        $display("%0t: %s: got value %0d eor %0b eof %0b",
                 $time, what, got.value, got.eor, got.eof);
    end
  endfunction

  always @(posedge clk) begin : watch
    cell_out_t want;
    cell_out_t got;
    if (rst) begin
      line_two_back = '0;
      line_one_back = '0;
      line_now      = '0;
      col_at        = 0;
      row_at        = 0;
      rows_reg      = ROWS_CFG_W'(1);
      cols_reg      = COLS_CFG_W'(1);
      expected_cells.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_GRID_ROWS) rows_reg = wr_data[ROWS_CFG_W-1:0];
        else if (wr_index == REG_GRID_COLS) cols_reg = wr_data[COLS_CFG_W-1:0];
        col_at = 0;
        row_at = 0;
      end
      if (results.valid && results.ready) begin
        got = cell_out_t'{results.cell_value, results.end_of_row, results.end_of_frame};
        if (expected_cells.size() == 0) begin
          report("result with nothing expected", 1'b0, got, got);
        end else begin
          want = expected_cells.pop_front();
          if (got.value !== want.value || got.eor !== want.eor || got.eof !== want.eof)
            report("result mismatch", 1'b1, want, got);
        end
      end
      if (cells.valid && cells.ready) advance_grid(cells.occupied);
    end
    pending = expected_cells.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the four-neighbor count raster unit: clock, reset, grid size
// writes, cell stimulus, result back-pressure, watchdog and verdict.
// Depends on fncr_pkg, fncr_in_if, fncr_out_if, fncr_checker and the unit itself.
module tb;
  import fncr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_CELLS   = 200;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = REG_GRID_ROWS;
  logic [CFG_DATA_W-1:0] wr_data  = '0;
  int                    errors;
  int                    pending;
  int                    idle_cycles = 0;
  int unsigned           cfg_rows = 1;
  int unsigned           cfg_cols = 1;
  bit                    hold_req = 1'b0;
  bit                    steady   = 1'b0;

  fncr_in_if  cells ();
  fncr_out_if results ();

  four_neighbor_count_raster_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cells    (cells),
    .results  (results)
  );

  fncr_checker grid_check (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cells    (cells),
    .results  (results),
    .errors   (errors),
    .pending  (pending)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic send_cell(input logic occ);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cells.valid    <= 1'b1;
    cells.occupied <= occ;
    do @(posedge clk); while (!cells.ready);
  endtask

  task automatic send_cells(input int count, input int pct);
    repeat (count) send_cell($urandom_range(0, 99) < pct);
  endtask

  // drain all results, then give the pipeline time to finish cells with no result
  task automatic settle();
    @(negedge clk);
    cells.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_regs(input int unsigned rows, input int unsigned cols);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_GRID_ROWS;
    wr_data  <= CFG_DATA_W'(rows);
    @(negedge clk);
    wr_index <= REG_GRID_COLS;
    wr_data  <= CFG_DATA_W'(cols);
    @(negedge clk);
    wr_en    <= 1'b0;
    cfg_rows = rows;
    cfg_cols = cols;
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the job queue fills and cells backs up
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        results.ready <= 1'b1;
      end else if (stall_left > 0) begin
        results.ready <= 1'b0;
        stall_left--;
      end else begin
        results.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (cells.valid && cells.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned rows;
    int unsigned cols;
    int          frame;
    int          count;
    int          pct;
    int          done;
    cells.valid    = 1'b0;
    cells.occupied = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes give a one by one grid
    send_cell(1'b1);
    send_cell(1'b0);
    settle();
    // zero sizes act as one
    write_regs(0, 0);
    send_cell(1'b1);
    settle();
    // plus sign: the center sees all four neighbors
    write_regs(3, 3);
    for (int i = 0; i < 9; i++) send_cell(i[0]);
    settle();
    // stop in the middle of a frame, the next write restarts it
    write_regs(4, 5);
    send_cells(7, 50);
    settle();

    // back-pressure run
    write_regs(5, 8);
    hold_req = 1'b1;
    send_cells(80, 50);
    settle();
    // oversized columns saturate, widest final row flush
    write_regs(1, 63);
    send_cells(32, 50);
    settle();
    write_regs(2, 32);
    send_cells(64, 50);
    settle();
    write_regs(MAX_ROWS, MAX_COLS);
    send_cells(70, 40);
    settle();
    // oversized rows saturate instead of wrapping to one row
    write_regs(MAX_ROWS + 1, 1);
    send_cells(24, 50);
    settle();

    done = 0;
    while (done < RANDOM_CELLS) begin
      case ($urandom_range(0, 7))
        0:       rows = 0;
        1:       rows = 1;
        default: rows = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       cols = 0;
        1:       cols = 1;
        2:       cols = MAX_COLS;
        3:       cols = $urandom_range(MAX_COLS + 1, 63);
        default: cols = $urandom_range(2, 8);
      endcase
      write_regs(rows, cols);
      frame  = fit_size(cfg_rows, MAX_ROWS) * fit_size(cfg_cols, MAX_COLS);
      pct    = $urandom_range(5, 95);
      steady = ($urandom_range(0, 4) == 0);
      count  = frame * $urandom_range(1, 2);
      if (frame > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, frame - 1);
      send_cells(count, pct);
      done += count;
      settle();
    end
    steady = 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
